[design/ckfd_pkg.sv]
// ----------------------------------------------------------------------------
// ckfd_pkg : keypad frame decoder shared definitions
// Status and key codes, frame constants, the record passed from the frame
// assembler to the key decoder, and the key decode functions.
// ----------------------------------------------------------------------------
package ckfd_pkg;

   // frame constants
   localparam logic [7:0] HDR_BYTE  = 8'hE5;
   localparam logic [7:0] LONG_MARK = 8'h80;
   localparam logic [7:0] CSUM_XOR  = 8'hA5;
   localparam logic [3:0] SHORT_LEN = 4'd7;
   localparam logic [3:0] LONG_LEN  = 4'd9;

   // short frame command bytes
   localparam logic [7:0] CMD_SETUP   = 8'h02;
   localparam logic [7:0] CMD_REWIND  = 8'h03;
   localparam logic [7:0] CMD_ENTER   = 8'h04;
   localparam logic [7:0] CMD_FORWARD = 8'h05;
   localparam logic [7:0] CMD_PAUSE   = 8'h06;
   localparam logic [7:0] CMD_PANIC   = 8'h07;
   localparam logic [7:0] CMD_NUMBER  = 8'h18;
   localparam logic [7:0] CMD_SEQ     = 8'h20;
   localparam logic [7:0] CMD_SEARCH  = 8'h21;
   localparam logic [7:0] CMD_ARCHIVE = 8'h32;
   localparam logic [7:0] CMD_LOCK    = 8'h33;
   localparam logic [7:0] CMD_ZOOM    = 8'h34;
   localparam logic [7:0] CMD_DISPLAY = 8'h35;

   // long frame function byte for return
   localparam logic [7:0] FUNC_RETURN = 8'hA1;

   // default depth of the queue between assembler and decoder
   localparam int CKFD_QUEUE_DEPTH = 2;

   typedef enum logic [1:0] {
      STATUS_PENDING  = 2'd0,
      STATUS_ERROR    = 2'd1,
      STATUS_COMPLETE = 2'd2
   } status_type;

   typedef enum logic [4:0] {
      KEY_NONE     = 5'd0,
      KEY_SETUP    = 5'd1,
      KEY_REWIND   = 5'd2,
      KEY_ENTER    = 5'd3,
      KEY_FORWARD  = 5'd4,
      KEY_PAUSE    = 5'd5,
      KEY_PANIC    = 5'd6,
      KEY_NUMBER   = 5'd7,
      KEY_SEQUENCE = 5'd8,
      KEY_SEARCH   = 5'd9,
      KEY_ARCHIVE  = 5'd10,
      KEY_LOCK     = 5'd11,
      KEY_ZOOM     = 5'd12,
      KEY_DISPLAY  = 5'd13,
      KEY_RETURN   = 5'd14,
      KEY_RIGHT    = 5'd15,
      KEY_LEFT     = 5'd16,
      KEY_UP       = 5'd17,
      KEY_DOWN     = 5'd18
   } key_type;

   // one classified item from the assembler
   typedef struct packed {
      status_type status;
      logic       long_frame;
      logic [7:0] addr;     // byte 2
      logic [7:0] cmd;      // byte 3
      logic [7:0] arg;      // byte 5
      logic [7:0] pan;      // byte 6
      logic [7:0] tilt;     // byte 7
   } rec_type;

   function automatic key_type decode_short(input logic [7:0] cmd, input logic [7:0] sub);
      key_type key;
      case (cmd)
         CMD_SETUP:   key = KEY_SETUP;
         CMD_REWIND:  key = KEY_REWIND;
         CMD_ENTER:   key = KEY_ENTER;
         CMD_FORWARD: key = KEY_FORWARD;
         CMD_PAUSE:   key = KEY_PAUSE;
         CMD_PANIC:   key = KEY_PANIC;
         CMD_NUMBER:  key = (sub inside {[8'd1:8'd13], [8'd15:8'd17]}) ? KEY_NUMBER : KEY_NONE;
         CMD_SEQ:     key = KEY_SEQUENCE;
         CMD_SEARCH:  key = KEY_SEARCH;
         CMD_ARCHIVE: key = KEY_ARCHIVE;
         CMD_LOCK:    key = KEY_LOCK;
         CMD_ZOOM:    key = KEY_ZOOM;
         CMD_DISPLAY: key = KEY_DISPLAY;
         default:     key = KEY_NONE;
      endcase
      return key;
   endfunction

   function automatic key_type decode_long(input logic [7:0] func, input logic [7:0] pan,
                                           input logic [7:0] tilt);
      key_type key;
      if (func == FUNC_RETURN)
         key = KEY_RETURN;
      else if (pan inside {[8'h01:8'h3F]})
         key = KEY_RIGHT;
      else if (pan inside {[8'h81:8'hBF]})
         key = KEY_LEFT;
      else if (tilt inside {[8'h01:8'h3F]})
         key = KEY_UP;
      else if (tilt inside {[8'h81:8'hBF]})
         key = KEY_DOWN;
      else
         key = KEY_NONE;
      return key;
   endfunction

endpackage

[design/camera_keypad_frame_decoder_unit.sv]
// ----------------------------------------------------------------------------
// camera_keypad_frame_decoder_unit : keypad serial frame decoder
// Path: a pushed byte is classified into a record that is held in the queue,
//   then decoded into the output register; either step can stall.
// Throughput: one byte per cycle while req_full is low; the per-byte checksum is a running 8-bit add.
// Reset: synchronous; clears byte count, frame length, queue and address.
// ----------------------------------------------------------------------------
module camera_keypad_frame_decoder_unit
   import ckfd_pkg::*;
#(
   parameter int QUEUE_DEPTH = CKFD_QUEUE_DEPTH
) (
   input  logic       clock,
   input  logic       reset,
   input  logic       req_push,
   output logic       req_full,
   input  logic [7:0] req_rx_byte,
   output logic       rsp_empty,
   input  logic       rsp_pop,
   output logic [1:0] rsp_frame_status,
   output logic [4:0] rsp_key_code,
   input  logic       csr_write_en,
   input  logic [7:0] csr_write_data
);

   logic [7:0] device_address_ff;
   logic       accept;
   logic       rec_valid;
   rec_type    front_rec;
   rec_type    back_rec;
   logic       q_empty;
   logic       q_pop;

   // device address register
   always_ff @(posedge clock) begin
      if (reset)
         device_address_ff <= 8'd0;
      else if (csr_write_en)
         device_address_ff <= csr_write_data;
   end

   assign accept = req_push && !req_full;

   ckfd_front u_front (
      .clock     (clock),
      .reset     (reset),
      .accept    (accept),
      .rx_byte   (req_rx_byte),
      .rec_valid (rec_valid),
      .rec       (front_rec)
   );

   ckfd_queue #(
      .DEPTH (QUEUE_DEPTH)
   ) u_queue (
      .clock    (clock),
      .reset    (reset),
      .push     (rec_valid),
      .push_rec (front_rec),
      .full     (req_full),
      .pop      (q_pop),
      .pop_rec  (back_rec),
      .empty    (q_empty)
   );

   ckfd_back u_back (
      .clock            (clock),
      .reset            (reset),
      .device_address   (device_address_ff),
      .q_empty          (q_empty),
      .q_rec            (back_rec),
      .q_pop            (q_pop),
      .rsp_empty        (rsp_empty),
      .rsp_pop          (rsp_pop),
      .rsp_frame_status (rsp_frame_status),
      .rsp_key_code     (rsp_key_code)
   );

endmodule

[design/ckfd_front.sv]
// ----------------------------------------------------------------------------
// ckfd_front : frame assembler
// Counts bytes, checks the header, picks the frame length, keeps a running
// checksum and captures the bytes the key decoder needs. Emits one
// classified record per accepted byte.
// ----------------------------------------------------------------------------
module ckfd_front
   import ckfd_pkg::*;
(
   input  logic       clock,
   input  logic       reset,
   input  logic       accept,
   input  logic [7:0] rx_byte,
   output logic       rec_valid,
   output rec_type    rec
);

   logic [3:0] byte_count_ff, byte_count_in;
   logic       long_ff, long_in;
   logic [7:0] sum_ff, sum_in;
   logic [7:0] addr_ff, cmd_ff, arg_ff, pan_ff, tilt_ff;
   logic [3:0] count_next;
   logic [3:0] frame_len;
   status_type status;

   // classify the incoming byte
   always_comb begin
      count_next    = byte_count_ff + 4'd1;
      long_in       = long_ff;
      byte_count_in = byte_count_ff;
      sum_in        = sum_ff;
      status        = STATUS_PENDING;
      if (byte_count_ff == 4'd3)
         long_in = (rx_byte == LONG_MARK);
      frame_len = long_in ? LONG_LEN : SHORT_LEN;
      if (byte_count_ff == 4'd0 && rx_byte != HDR_BYTE) begin
         status        = STATUS_ERROR;
         long_in       = long_ff;
         byte_count_in = 4'd0;
         sum_in        = 8'd0;
      end else if (count_next == frame_len) begin
         status        = (rx_byte == (sum_ff ^ CSUM_XOR)) ? STATUS_COMPLETE : STATUS_ERROR;
         byte_count_in = 4'd0;
         sum_in        = 8'd0;
      end else begin
         byte_count_in = count_next;
         sum_in        = sum_ff + rx_byte;
      end
   end

   // control state
   always_ff @(posedge clock) begin
      if (reset) begin
         byte_count_ff <= 4'd0;
         long_ff       <= 1'b0;
         sum_ff        <= 8'd0;
      end else if (accept) begin
         byte_count_ff <= byte_count_in;
         long_ff       <= long_in;
         sum_ff        <= sum_in;
      end
   end

   // capture the bytes used by the key decoder
   always_ff @(posedge clock) begin
      if (accept) begin
         case (byte_count_ff)
            4'd2:    addr_ff <= rx_byte;
            4'd3:    cmd_ff  <= rx_byte;
            4'd5:    arg_ff  <= rx_byte;
            4'd6:    pan_ff  <= rx_byte;
            4'd7:    tilt_ff <= rx_byte;
            default: ;
         endcase
      end
   end

   // record toward the queue
   assign rec_valid       = accept;
   assign rec.status      = status;
   assign rec.long_frame  = long_in;
   assign rec.addr        = addr_ff;
   assign rec.cmd         = cmd_ff;
   assign rec.arg         = arg_ff;
   assign rec.pan         = pan_ff;
   assign rec.tilt        = tilt_ff;

   // frame always restarts after an error or a complete frame
   a_restart: assert property (@(posedge clock) disable iff (reset)
      accept && status != STATUS_PENDING |=> byte_count_ff == 4'd0)
      else $error("byte count not cleared after frame end");

   a_count_range: assert property (@(posedge clock) disable iff (reset)
      byte_count_ff < LONG_LEN)
      else $error("byte count ran past the long frame length");

endmodule

[design/ckfd_queue.sv]
// ----------------------------------------------------------------------------
// ckfd_queue : record queue
// Short first-in first-out queue between the frame assembler and the key
// decoder, so that each side can stall on its own.
// ----------------------------------------------------------------------------
module ckfd_queue
   import ckfd_pkg::*;
#(
   parameter int DEPTH = CKFD_QUEUE_DEPTH
) (
   input  logic    clock,
   input  logic    reset,
   input  logic    push,
   input  rec_type push_rec,
   output logic    full,
   input  logic    pop,
   output rec_type pop_rec,
   output logic    empty
);

   localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
   localparam int CNT_W = $clog2(DEPTH + 1);

   rec_type             entry_ff [DEPTH];
   logic [PTR_W-1:0]    wr_ptr_ff, wr_ptr_in;
   logic [PTR_W-1:0]    rd_ptr_ff, rd_ptr_in;
   logic [CNT_W-1:0]    cnt_ff, cnt_in;
   logic                do_push, do_pop;

   assign full    = (cnt_ff == CNT_W'(DEPTH));
   assign empty   = (cnt_ff == '0);
   assign do_push = push && !full;
   assign do_pop  = pop && !empty;
   assign pop_rec = entry_ff[rd_ptr_ff];

   // pointer and count update
   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      cnt_in    = cnt_ff;
      if (do_push)
         wr_ptr_in = (wr_ptr_ff == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_ff + PTR_W'(1);
      if (do_pop)
         rd_ptr_in = (rd_ptr_ff == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_ff + PTR_W'(1);
      if (do_push && !do_pop)
         cnt_in = cnt_ff + CNT_W'(1);
      else if (do_pop && !do_push)
         cnt_in = cnt_ff - CNT_W'(1);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         cnt_ff    <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         cnt_ff    <= cnt_in;
      end
   end

   // entry storage
   always_ff @(posedge clock) begin
      if (do_push)
         entry_ff[wr_ptr_ff] <= push_rec;
   end

   a_no_overflow: assert property (@(posedge clock) disable iff (reset)
      cnt_ff <= CNT_W'(DEPTH))
      else $error("queue count above depth");

   a_push_count: assert property (@(posedge clock) disable iff (reset)
      push && !full && !(pop && !empty) |=> cnt_ff == $past(cnt_ff) + CNT_W'(1))
      else $error("queue count missed a push");

endmodule

[design/ckfd_back.sv]
// ----------------------------------------------------------------------------
// ckfd_back : key decoder
// Takes classified records from the queue, checks the device address on
// complete frames, decodes the key and holds the result in the output
// register until it is popped.
// ----------------------------------------------------------------------------
module ckfd_back
   import ckfd_pkg::*;
(
   input  logic       clock,
   input  logic       reset,
   input  logic [7:0] device_address,
   input  logic       q_empty,
   input  rec_type    q_rec,
   output logic       q_pop,
   output logic       rsp_empty,
   input  logic       rsp_pop,
   output logic [1:0] rsp_frame_status,
   output logic [4:0] rsp_key_code
);

   logic       out_valid_ff, out_valid_in;
   status_type status_ff;
   key_type    key_ff, key_in;
   logic       load;

   // load the output register whenever it is free or being taken
   assign load         = !q_empty && (!out_valid_ff || rsp_pop);
   assign q_pop        = load;
   assign out_valid_in = load || (out_valid_ff && !rsp_pop);

   // key decode
   always_comb begin
      key_in = KEY_NONE;
      if (q_rec.status == STATUS_COMPLETE && q_rec.addr == device_address) begin
         if (q_rec.long_frame)
            key_in = decode_long(q_rec.arg, q_rec.pan, q_rec.tilt);
         else
            key_in = decode_short(q_rec.cmd, q_rec.arg);
      end
   end

   always_ff @(posedge clock) begin
      if (reset)
         out_valid_ff <= 1'b0;
      else
         out_valid_ff <= out_valid_in;
   end

   always_ff @(posedge clock) begin
      if (load) begin
         status_ff <= q_rec.status;
         key_ff    <= key_in;
      end
   end

   assign rsp_empty        = !out_valid_ff;
   assign rsp_frame_status = status_ff;
   assign rsp_key_code     = key_ff;

   a_key_on_complete: assert property (@(posedge clock) disable iff (reset)
      out_valid_ff && key_ff != KEY_NONE |-> status_ff == STATUS_COMPLETE)
      else $error("key reported on a frame that is not complete");

   a_hold_stalled: assert property (@(posedge clock) disable iff (reset)
      out_valid_ff && !rsp_pop |=> out_valid_ff && $stable(key_ff) && $stable(status_ff))
      else $error("stalled result changed");

endmodule

[tb/camera_keypad_frame_decoder_unit_tb.sv]
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// camera_keypad_frame_decoder_unit_tb : keypad frame decoder testbench
// Pushes serial bytes through the input queue port and predicts a status and
// key code for every byte. Each popped result is checked against the oldest
// prediction. The stimulus mixes valid short and long frames with bad headers,
// bad checksums, cut-off frames and line noise. Both sides stall at random,
// and the device address is changed between phases.
// ----------------------------------------------------------------------------
module camera_keypad_frame_decoder_unit_tb
   import ckfd_pkg::*;
();

   localparam int CYCLE_LIMIT = 200000;
   localparam int DRAIN_CYCLES = 4;

   typedef struct {
      status_type status;
      key_type    key;
   } decode_result_type;

   logic       clock = 1'b0;
   logic       reset = 1'b1;
   logic       req_push = 1'b0;
   logic       req_full;
   logic [7:0] req_rx_byte = 8'h00;
   logic       rsp_empty;
   logic       rsp_pop = 1'b0;
   logic [1:0] rsp_frame_status;
   logic [4:0] rsp_key_code;
   logic       csr_write_en = 1'b0;
   logic [7:0] csr_write_data = 8'h00;

   // byte stream waiting to be offered and decodes waiting to be popped
   logic [7:0]        rx_bytes_q[$];
   decode_result_type expected_decodes[$];

   // predictor state
   logic [7:0] dev_addr = 8'h00;
   logic [7:0] frm_bytes [0:8];
   logic [3:0] frm_count = 4'd0;
   logic       frm_long = 1'b0;

   int  error_count = 0;
   int  cycle_count = 0;
   int  queued_bytes = 0;
   int  send_gap = 0;
   int  pop_gap = 0;
   int  hold_left = 0;
   bit  no_idle = 1'b0;

   camera_keypad_frame_decoder_unit dut (
      .clock            (clock),
      .reset            (reset),
      .req_push         (req_push),
      .req_full         (req_full),
      .req_rx_byte      (req_rx_byte),
      .rsp_empty        (rsp_empty),
      .rsp_pop          (rsp_pop),
      .rsp_frame_status (rsp_frame_status),
      .rsp_key_code     (rsp_key_code),
      .csr_write_en     (csr_write_en),
      .csr_write_data   (csr_write_data)
   );

   always #5 clock = ~clock;

   // run limit
   always @(posedge clock) begin
      cycle_count++;
      if (cycle_count > CYCLE_LIMIT) begin
         $display("CHECK FAILED");
         $finish;
      end
   end

   // mostly short gaps, a few long ones
   function automatic int pick_gap();
      int r;
      r = $urandom_range(0, 99);
      if (no_idle) return 0;
      if (r < 55) return 0;
      if (r < 90) return $urandom_range(1, 3);
      return $urandom_range(6, 25);
   endfunction

   // mod-256 sum of the first n bytes, xor the checksum mask
   function automatic logic [7:0] frame_checksum(input logic [7:0] fb [0:8], input int n);
      logic [7:0] sum;
      sum = 8'h00;
      for (int i = 0; i < n; i++) sum += fb[i];
      return sum ^ CSUM_XOR;
   endfunction

   function automatic key_type short_key(input logic [7:0] cmd, input logic [7:0] sub);
      key_type k;
      case (cmd)
         CMD_SETUP:   k = KEY_SETUP;
         CMD_REWIND:  k = KEY_REWIND;
         CMD_ENTER:   k = KEY_ENTER;
         CMD_FORWARD: k = KEY_FORWARD;
         CMD_PAUSE:   k = KEY_PAUSE;
         CMD_PANIC:   k = KEY_PANIC;
         CMD_NUMBER:  begin
            // sub-code 14 is a hole in the number range
            if ((sub >= 8'd1 && sub <= 8'd13) || (sub >= 8'd15 && sub <= 8'd17))
               k = KEY_NUMBER;
            else
               k = KEY_NONE;
         end
         CMD_SEQ:     k = KEY_SEQUENCE;
         CMD_SEARCH:  k = KEY_SEARCH;
         CMD_ARCHIVE: k = KEY_ARCHIVE;
         CMD_LOCK:    k = KEY_LOCK;
         CMD_ZOOM:    k = KEY_ZOOM;
         CMD_DISPLAY: k = KEY_DISPLAY;
         default:     k = KEY_NONE;
      endcase
      return k;
   endfunction

   // return wins, then pan right/left, then tilt up/down
   function automatic key_type long_key(input logic [7:0] func, input logic [7:0] pan,
                                        input logic [7:0] tilt);
      if (func == FUNC_RETURN) return KEY_RETURN;
      if (pan >= 8'h01 && pan <= 8'h3F) return KEY_RIGHT;
      if (pan >= 8'h81 && pan <= 8'hBF) return KEY_LEFT;
      if (tilt >= 8'h01 && tilt <= 8'h3F) return KEY_UP;
      if (tilt >= 8'h81 && tilt <= 8'hBF) return KEY_DOWN;
      return KEY_NONE;
   endfunction

   function automatic void clear_frame();
      for (int i = 0; i < 9; i++) frm_bytes[i] = 8'h00;
      frm_count = 4'd0;
   endfunction

   // predict the status and key caused by one accepted byte
   function automatic void decode_rx_byte(input logic [7:0] b);
      logic [3:0]        len;
      decode_result_type res;
      res.status = STATUS_PENDING;
      res.key = KEY_NONE;
      if (frm_count > 4'd8) frm_count = 4'd8;
      frm_bytes[frm_count] = b;
      frm_count++;
      if (frm_count == 4'd1 && b != HDR_BYTE) begin
         clear_frame();
         res.status = STATUS_ERROR;
      end else begin
         // frame length is latched on the fourth byte and held until the next one
         if (frm_count == 4'd4) frm_long = (frm_bytes[3] == LONG_MARK);
         len = frm_long ? LONG_LEN : SHORT_LEN;
         if (frm_count == len) begin
            if (frm_bytes[len - 1] != frame_checksum(frm_bytes, len - 1)) begin
               res.status = STATUS_ERROR;
            end else begin
               res.status = STATUS_COMPLETE;
               if (frm_bytes[2] == dev_addr)
                  res.key = frm_long ? long_key(frm_bytes[5], frm_bytes[6], frm_bytes[7])
                                     : short_key(frm_bytes[3], frm_bytes[5]);
            end
            clear_frame();
         end
      end
      expected_decodes.push_back(res);
   endfunction

   // sender: offers the next queued byte after a random gap
   always @(posedge clock) begin
      if (reset) begin
         req_push <= 1'b0;
      end else begin
         if (req_push && !req_full) begin
            decode_rx_byte(rx_bytes_q.pop_front());
            send_gap = pick_gap();
         end else if (send_gap > 0) begin
            send_gap--;
         end
         if (send_gap == 0 && rx_bytes_q.size() != 0) begin
            req_push <= 1'b1;
            req_rx_byte <= rx_bytes_q[0];
         end else begin
            req_push <= 1'b0;
         end
      end
   end

   // receiver: checks each popped result, stalls at random or for a long hold
   always @(posedge clock) begin
      decode_result_type e;
      if (reset) begin
         rsp_pop <= 1'b0;
      end else begin
         if (rsp_pop && !rsp_empty) begin
            if (expected_decodes.size() == 0) begin
               $error("unexpected item: frame_status %0d key_code %0d",
                      rsp_frame_status, rsp_key_code);
               error_count++;
            end else begin
               e = expected_decodes.pop_front();
               if (rsp_frame_status !== e.status) begin
                  $error("frame_status mismatch: expected %0d, actual %0d",
                         e.status, rsp_frame_status);
                  error_count++;
               end
               if (rsp_key_code !== e.key) begin
                  $error("key_code mismatch: expected %0d, actual %0d", e.key, rsp_key_code);
                  error_count++;
               end
            end
            pop_gap = pick_gap();
         end else if (pop_gap > 0) begin
            pop_gap--;
         end
         if (hold_left > 0) hold_left--;
         rsp_pop <= (hold_left == 0 && pop_gap == 0);
      end
   end

   function automatic void offer_byte(input logic [7:0] b);
      rx_bytes_q.push_back(b);
      queued_bytes++;
   endfunction

   // queue one frame; keep is the number of bytes sent (cut-off frames)
   function automatic void queue_frame(input bit is_long, input logic [7:0] addr,
                                       input logic [7:0] cmd, input logic [7:0] b4,
                                       input logic [7:0] sub, input logic [7:0] pan,
                                       input logic [7:0] tilt, input bit corrupt,
                                       input int keep);
      logic [7:0] fb [0:8];
      int         len;
      len = is_long ? LONG_LEN : SHORT_LEN;
      fb[0] = HDR_BYTE;
      fb[1] = 8'($urandom_range(0, 255));
      fb[2] = addr;
      fb[3] = is_long ? LONG_MARK : ((cmd == LONG_MARK) ? CMD_SETUP : cmd);
      fb[4] = b4;
      fb[5] = sub;
      fb[6] = pan;
      fb[7] = tilt;
      fb[8] = 8'h00;
      fb[len - 1] = frame_checksum(fb, len - 1);
      if (corrupt) fb[len - 1] ^= 8'($urandom_range(1, 255));
      for (int i = 0; i < len && i < keep; i++) offer_byte(fb[i]);
   endfunction

   function automatic logic [7:0] pick_cmd();
      logic [7:0] cmds [0:12];
      cmds = '{CMD_SETUP, CMD_REWIND, CMD_ENTER, CMD_FORWARD, CMD_PAUSE, CMD_PANIC,
               CMD_NUMBER, CMD_SEQ, CMD_SEARCH, CMD_ARCHIVE, CMD_LOCK, CMD_ZOOM,
               CMD_DISPLAY};
      if ($urandom_range(0, 99) < 15) return 8'($urandom_range(0, 255));
      return cmds[$urandom_range(0, 12)];
   endfunction

   // pan and tilt values near the range edges, or anything
   function automatic logic [7:0] pick_axis();
      logic [7:0] edges [0:8];
      edges = '{8'h00, 8'h01, 8'h3F, 8'h40, 8'h80, 8'h81, 8'hBF, 8'hC0, 8'hFF};
      if ($urandom_range(0, 1) == 0) return edges[$urandom_range(0, 8)];
      return 8'($urandom_range(0, 255));
   endfunction

   function automatic void queue_random_traffic(input int n_bytes);
      int         stop_at;
      int         r;
      logic [7:0] addr;
      logic [7:0] sub;
      logic [7:0] func;
      stop_at = queued_bytes + n_bytes;
      while (queued_bytes < stop_at) begin
         r = $urandom_range(0, 99);
         addr = ($urandom_range(0, 9) < 8) ? dev_addr : 8'($urandom_range(0, 255));
         sub = ($urandom_range(0, 1) == 0) ? 8'($urandom_range(0, 20))
                                           : 8'($urandom_range(0, 255));
         func = ($urandom_range(0, 3) == 0) ? FUNC_RETURN : 8'($urandom_range(0, 255));
         if (r < 40)
            queue_frame(1'b0, addr, pick_cmd(), 8'($urandom_range(0, 255)), sub,
                        pick_axis(), pick_axis(), 1'b0, 9);
         else if (r < 70)
            queue_frame(1'b1, addr, 8'h00, 8'($urandom_range(0, 255)), func,
                        pick_axis(), pick_axis(), 1'b0, 9);
         else if (r < 78)
            queue_frame(1'($urandom_range(0, 1)), addr, pick_cmd(),
                        8'($urandom_range(0, 255)),
                        sub, pick_axis(), pick_axis(), 1'b1, 9);
         else if (r < 86)
            queue_frame(1'($urandom_range(0, 1)), addr, pick_cmd(),
                        8'($urandom_range(0, 255)),
                        sub, pick_axis(), pick_axis(), 1'b0, $urandom_range(1, 6));
         else
            repeat ($urandom_range(1, 4)) offer_byte(8'($urandom_range(0, 255)));
      end
   endfunction

   task automatic wait_drained();
      while (rx_bytes_q.size() != 0 || expected_decodes.size() != 0) @(posedge clock);
   endtask

   // address change only while the block is empty
   task automatic write_device_address(input logic [7:0] value);
      wait_drained();
      repeat (DRAIN_CYCLES) @(posedge clock);
      csr_write_en <= 1'b1;
      csr_write_data <= value;
      @(posedge clock);
      csr_write_en <= 1'b0;
      dev_addr = value;
   endtask

   initial begin
      for (int i = 0; i < 9; i++) frm_bytes[i] = 8'h00;
      repeat (12) @(posedge clock);
      reset <= 1'b0;

      // directed: bad headers, a short and a long frame, a bad checksum
      write_device_address(8'h00);
      offer_byte(8'h00);
      offer_byte(8'hFF);
      queue_frame(1'b0, 8'h00, CMD_SETUP, 8'h00, 8'h00, 8'h00, 8'h00, 1'b0, 9);
      queue_frame(1'b1, 8'h00, 8'h00, 8'hFF, FUNC_RETURN, 8'hFF, 8'hFF, 1'b0, 9);
      queue_frame(1'b0, 8'h00, CMD_NUMBER, 8'hFF, 8'd14, 8'h00, 8'h00, 1'b1, 9);

      write_device_address(8'hFF);
      queue_random_traffic(100);

      // long receiver hold while the sender keeps pushing
      write_device_address(8'($urandom_range(0, 255)));
      hold_left = 80;
      queue_random_traffic(100);

      // back-to-back traffic with no idling on either side
      write_device_address(8'h00);
      no_idle = 1'b1;
      queue_random_traffic(100);
      wait_drained();
      no_idle = 1'b0;

      write_device_address(8'($urandom_range(0, 255)));
      queue_random_traffic(100);

      write_device_address(8'hA5);
      queue_random_traffic(100);

      wait_drained();
      repeat (DRAIN_CYCLES * 4) @(posedge clock);
      if (error_count == 0 && expected_decodes.size() == 0)
         $display("CHECK OK");
      else
         $display("CHECK FAILED");
      $finish;
   end

endmodule
